>>> src/remote_control_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Remote control frame receiver - assertion macros
// Shorthand for clocked implications, both checked with reset masked.
// ----------------------------------------------------------------------------
`ifndef REMOTE_CONTROL_FRAME_RECEIVER_ASSERT_SVH
`define REMOTE_CONTROL_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define RCFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define RCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> src/rcfr_pkg.sv
// ----------------------------------------------------------------------------
// Remote control frame receiver - package
// Frame layout, error codes, register indexes and the check byte function.
// ----------------------------------------------------------------------------
package rcfr_pkg;

   localparam int BYTE_W      = 8;
   localparam int BODY_BYTES  = 6;              // header, four sticks, switches
   localparam int POS_W       = 3;
   localparam logic [POS_W-1:0] LAST_POS = 3'd6; // position of the check byte
   localparam int RSP_DATA_W  = 40;

   // check byte masks per stick
   localparam logic [BYTE_W-1:0] MASK_THRUST = 8'b1100_0000;
   localparam logic [BYTE_W-1:0] MASK_YAW    = 8'b0011_0000;
   localparam logic [BYTE_W-1:0] MASK_PITCH  = 8'b0000_1100;
   localparam logic [BYTE_W-1:0] MASK_ROLL   = 8'b0000_0011;

   // switch byte bits
   localparam int SW_LEFT_BIT  = 0;
   localparam int SW_RIGHT_BIT = 1;

   // register reset values
   localparam logic [BYTE_W-1:0] HEADER_RST    = 8'd84;  // ASCII T
   localparam logic [BYTE_W-1:0] ARM_X_MAX_RST = 8'd5;
   localparam logic [BYTE_W-1:0] ARM_Y_MIN_RST = 8'd250;

   // register indexes
   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER    = 2'd0,
      CSR_ARM_X_MAX = 2'd1,
      CSR_ARM_Y_MIN = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_HEADER = 2'd1,
      ERR_CHECK  = 2'd2
   } err_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_value;
      logic [BYTE_W-1:0] arm_x_max;
      logic [BYTE_W-1:0] arm_y_min;
   } cfg_type;

   // one complete frame handed from assembler to decoder
   typedef struct packed {
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] thrust;
      logic [BYTE_W-1:0] yaw;
      logic [BYTE_W-1:0] pitch;
      logic [BYTE_W-1:0] roll;
      logic [BYTE_W-1:0] switches;
      logic [BYTE_W-1:0] check;
   } frame_type;

   typedef struct packed {
      logic              frame_ok;
      err_type           error_code;
      logic [BYTE_W-1:0] thrust;
      logic [BYTE_W-1:0] yaw;
      logic [BYTE_W-1:0] pitch;
      logic [BYTE_W-1:0] roll;
      logic              left_pressed;
      logic              right_pressed;
      logic              armed;
      logic              stop_motors;
   } result_type;

   function automatic logic [BYTE_W-1:0] check_of(input frame_type f);
      check_of = (f.thrust & MASK_THRUST) | (f.yaw & MASK_YAW) |
                 (f.pitch & MASK_PITCH) | (f.roll & MASK_ROLL);
   endfunction

endpackage

>>> src/remote_control_frame_receiver.sv
// ----------------------------------------------------------------------------
// Remote control frame receiver - top level
// Groups received bytes into seven-byte frames and reports each frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per request in req_tdata[7:0]. Bytes are
//   counted in sevens from reset with no resync: header, thrust, yaw, pitch,
//   roll, switch byte, check byte.
//   rsp_* carries one result per completed frame, none for other bytes.
//   csr_* writes header_value (0), arm_x_max (1), arm_y_min (2); other
//   indexes are ignored. Write only while no frame is in flight.
// Timing:
//   A byte is taken every cycle unless the check byte is stalled. The
//   check byte fills the frame register of the assembler, and the result
//   register of the decoder, which drives rsp, takes the frame once free.
//   Sustained rate is one byte per cycle while rsp_tready keeps up.
// Reset:
//   Byte count, kept sticks, switch history and arming clear; registers take
//   their default values; rsp_tvalid drops.
// Stall:
//   While rsp_tready is low the result holds; the next frame is kept in the
//   frame register, and the check byte after it waits in req until it frees.
// ----------------------------------------------------------------------------
module remote_control_frame_receiver
   import rcfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] rx_byte
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] frame_ok, [2:1] error_code, [10:3] thrust, [18:11] yaw,
   // [26:19] pitch, [34:27] roll, [35] left_pressed, [36] right_pressed,
   // [37] armed, [38] stop_motors, [39] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // register write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata
);

   cfg_type    cfg_ff;
   logic       frame_valid;
   logic       frame_take;
   frame_type  frame;
   result_type rsp;

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_value <= HEADER_RST;
         cfg_ff.arm_x_max    <= ARM_X_MAX_RST;
         cfg_ff.arm_y_min    <= ARM_Y_MIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER:    cfg_ff.header_value <= csr_wdata;
            CSR_ARM_X_MAX: cfg_ff.arm_x_max    <= csr_wdata;
            CSR_ARM_Y_MIN: cfg_ff.arm_y_min    <= csr_wdata;
            default: ;
         endcase
      end
   end

   rcfr_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .byte_ready  (req_tready),
      .byte_data   (req_tdata),
      .frame_valid (frame_valid),
      .frame_take  (frame_take),
      .frame       (frame)
   );

   rcfr_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .frame_valid (frame_valid),
      .frame_take  (frame_take),
      .frame       (frame),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   // result packing, first field lowest
   assign rsp_tdata = {1'b0,
                       rsp.stop_motors,
                       rsp.armed,
                       rsp.right_pressed,
                       rsp.left_pressed,
                       rsp.roll,
                       rsp.pitch,
                       rsp.yaw,
                       rsp.thrust,
                       rsp.error_code,
                       rsp.frame_ok};

endmodule

>>> src/rcfr_assembler.sv
// ----------------------------------------------------------------------------
// Remote control frame receiver - frame assembler
// Collects bytes by position and registers a whole frame on its seventh byte.
// ----------------------------------------------------------------------------
module rcfr_assembler
   import rcfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   output logic              byte_ready,
   input  logic [BYTE_W-1:0] byte_data,
   output logic              frame_valid,
   input  logic              frame_take,
   output frame_type         frame
);

   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic              frame_valid_ff;
   logic              frame_valid_in;
   logic [BYTE_W-1:0] bytes_ff [BODY_BYTES];
   frame_type         frame_ff;
   logic              accept;
   logic              last_byte;

   // the check byte waits only while an earlier frame is still held
   assign last_byte  = (pos_ff == LAST_POS);
   assign byte_ready = !last_byte || !frame_valid_ff;
   assign accept     = byte_valid && byte_ready;

   // position counter and frame holding flag
   always_comb begin
      pos_in         = pos_ff;
      frame_valid_in = frame_valid_ff && !frame_take;
      if (accept) begin
         if (last_byte) begin
            pos_in         = '0;
            frame_valid_in = 1'b1;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   // byte store and completed frame register
   always_ff @(posedge clock) begin
      if (accept && !last_byte) begin
         bytes_ff[pos_ff] <= byte_data;
      end
      if (accept && last_byte) begin
         frame_ff <= '{header:   bytes_ff[0],
                       thrust:   bytes_ff[1],
                       yaw:      bytes_ff[2],
                       pitch:    bytes_ff[3],
                       roll:     bytes_ff[4],
                       switches: bytes_ff[5],
                       check:    byte_data};
      end
   end

   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

endmodule

>>> src/rcfr_decoder.sv
// ----------------------------------------------------------------------------
// Remote control frame receiver - frame decoder
// Checks a frame, updates kept sticks, switch history and arming, and
// registers the result.
// ----------------------------------------------------------------------------
module rcfr_decoder
   import rcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       frame_valid,
   output logic       frame_take,
   input  frame_type  frame,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   logic [BYTE_W-1:0] thrust_ff, yaw_ff, pitch_ff, roll_ff;
   logic [BYTE_W-1:0] thrust_in, yaw_in, pitch_in, roll_in;
   logic              prev_left_ff, prev_right_ff, armed_ff;
   logic              prev_left_in, prev_right_in, armed_in;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   result_type        rsp_in;
   logic              left_bit, right_bit;
   logic              lp, rp, gesture;
   err_type           err;

   // result register frees when empty or taken
   assign frame_take = frame_valid && (!rsp_valid_ff || rsp_ready);

   assign left_bit  = frame.switches[SW_LEFT_BIT];
   assign right_bit = frame.switches[SW_RIGHT_BIT];
   assign gesture   = (frame.thrust <= cfg.arm_x_max) && (frame.yaw >= cfg.arm_y_min);

   // header error takes priority over check error
   always_comb begin
      if (frame.header != cfg.header_value) begin
         err = ERR_HEADER;
      end else if (frame.check != check_of(frame)) begin
         err = ERR_CHECK;
      end else begin
         err = ERR_NONE;
      end
   end

   // next state: a bad frame leaves everything as it was
   always_comb begin
      thrust_in     = thrust_ff;
      yaw_in        = yaw_ff;
      pitch_in      = pitch_ff;
      roll_in       = roll_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      armed_in      = armed_ff;
      lp            = 1'b0;
      rp            = 1'b0;
      if (err == ERR_NONE) begin
         thrust_in     = frame.thrust;
         yaw_in        = frame.yaw;
         pitch_in      = frame.pitch;
         roll_in       = frame.roll;
         lp            = !left_bit && prev_left_ff;
         rp            = !right_bit && prev_right_ff;
         prev_left_in  = left_bit;
         prev_right_in = right_bit;
         // left press clears arming even with the gesture held
         if (lp) begin
            armed_in = 1'b0;
         end else if (gesture) begin
            armed_in = 1'b1;
         end
      end
      rsp_in = '{frame_ok:      (err == ERR_NONE),
                 error_code:    err,
                 thrust:        thrust_in,
                 yaw:           yaw_in,
                 pitch:         pitch_in,
                 roll:          roll_in,
                 left_pressed:  lp,
                 right_pressed: rp,
                 armed:         armed_in,
                 stop_motors:   lp};
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thrust_ff     <= '0;
         yaw_ff        <= '0;
         pitch_ff      <= '0;
         roll_ff       <= '0;
         prev_left_ff  <= 1'b0;
         prev_right_ff <= 1'b0;
         armed_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (frame_take) begin
            thrust_ff     <= thrust_in;
            yaw_ff        <= yaw_in;
            pitch_ff      <= pitch_in;
            roll_ff       <= roll_in;
            prev_left_ff  <= prev_left_in;
            prev_right_ff <= prev_right_in;
            armed_ff      <= armed_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (frame_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> src/rcfr_checker.sv
// ----------------------------------------------------------------------------
// Remote control frame receiver - port checker
// Watches the result channel for consistency of codes, flags and handshake.
// ----------------------------------------------------------------------------
`include "remote_control_frame_receiver_assert.svh"

module rcfr_checker
   import rcfr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // stalled result holds
   `RCFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // frame_ok exactly when no error is reported
   `RCFR_ASSERT_SAME(a_ok_vs_err, clock, reset, rsp_tvalid,
      rsp_tdata[0] == (rsp_tdata[2:1] == ERR_NONE))

   // no error code beyond bad check
   `RCFR_ASSERT_SAME(a_err_code, clock, reset, rsp_tvalid,
      rsp_tdata[2:1] == ERR_NONE || rsp_tdata[2:1] == ERR_HEADER ||
      rsp_tdata[2:1] == ERR_CHECK)

   // bad frames report no presses and no stop
   `RCFR_ASSERT_SAME(a_bad_quiet, clock, reset, rsp_tvalid && !rsp_tdata[0],
      !rsp_tdata[35] && !rsp_tdata[36] && !rsp_tdata[38])

   // stop comes only with a left press and leaves the block disarmed
   `RCFR_ASSERT_SAME(a_stop_disarm, clock, reset, rsp_tvalid && rsp_tdata[38],
      rsp_tdata[35] && !rsp_tdata[37])

endmodule

bind remote_control_frame_receiver rcfr_checker u_checker (.*);

>>> tb/sv/tb_remote_control_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Remote control frame receiver - testbench
// Drives received bytes in seven-byte frames under four register settings.
// An in-bench model of the frame decoder predicts each report, and every
// report from the block is compared field by field. Idle bursts fall on both
// sides, and one long result stall makes the block back up its input.
// ----------------------------------------------------------------------------
module tb_remote_control_frame_receiver;
   import rcfr_pkg::*;

   typedef logic [6:0][BYTE_W-1:0] frame_vec;   // [0] header ... [6] check

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_CYCLES     = 6;
   localparam int HOLD_CYCLES      = 60;
   localparam int FRAMES_PER_PHASE = 38;
   localparam int DIRECTED_FRAMES  = 4;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_HEADER;
   logic [BYTE_W-1:0]      csr_wdata  = '0;

   // frame decoder model state
   cfg_type           cfg_model = {HEADER_RST, ARM_X_MAX_RST, ARM_Y_MIN_RST};
   frame_vec          frame_buf;
   int                frame_pos = 0;
   logic [BYTE_W-1:0] kept_sticks [4] = '{default: '0};
   logic              prev_left  = 1'b0;
   logic              prev_right = 1'b0;
   logic              arm_state  = 1'b0;
   result_type        expected_frame_reports [$];

   // run control and tallies
   bit idle_on      = 1'b1;
   bit hold_results = 1'b0;
   int cycle_count     = 0;
   int mismatch_count  = 0;
   int bytes_accepted  = 0;
   int reports_checked = 0;
   int good_frames     = 0;
   int header_errors   = 0;
   int check_errors    = 0;
   int arm_frames      = 0;
   int motor_stops     = 0;
   int right_presses   = 0;

   // directed frames: extremes, both error kinds, arming and presses
   logic [BYTE_W-1:0] directed_frames [DIRECTED_FRAMES][7] = '{
      '{8'h54, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h03, 8'h36},  // good, arms at extreme sticks
      '{8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'hFF},  // bad header and bad check
      '{8'h54, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00},  // bad check only
      '{8'h54, 8'h05, 8'hFA, 8'hFF, 8'hFF, 8'hFC, 8'h3F}   // arm at limits plus both presses
   };
   result_type directed_reports [DIRECTED_FRAMES];

   remote_control_frame_receiver DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // check byte: masked bit pairs of the four sticks
   function automatic logic [BYTE_W-1:0] check_byte(input frame_vec f);
      return (f[1] & MASK_THRUST) | (f[2] & MASK_YAW) |
             (f[3] & MASK_PITCH) | (f[4] & MASK_ROLL);
   endfunction

   function automatic result_type frame_report(input logic ok, input err_type err,
                                               input logic [BYTE_W-1:0] thr, yw, pit, rol,
                                               input logic lp, rp, arm, stop);
      result_type r;
      r.frame_ok      = ok;
      r.error_code    = err;
      r.thrust        = thr;
      r.yaw           = yw;
      r.pitch         = pit;
      r.roll          = rol;
      r.left_pressed  = lp;
      r.right_pressed = rp;
      r.armed         = arm;
      r.stop_motors   = stop;
      return r;
   endfunction

   // model: take one accepted byte, queue a report when a frame completes
   task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
      result_type r;
      logic       left_bit;
      logic       right_bit;
      if (frame_pos < 6) begin
         frame_buf[frame_pos] = b;
         frame_pos++;
         return;
      end
      frame_pos = 0;
      frame_buf[6] = b;
      r = '0;
      if (frame_buf[0] != cfg_model.header_value) begin
         r.error_code = ERR_HEADER;
         header_errors++;
      end else if (b != check_byte(frame_buf)) begin
         r.error_code = ERR_CHECK;
         check_errors++;
      end else begin
         r.error_code = ERR_NONE;
         r.frame_ok   = 1'b1;
         good_frames++;
         for (int i = 0; i < 4; i++) kept_sticks[i] = frame_buf[i+1];
         left_bit  = frame_buf[5][SW_LEFT_BIT];
         right_bit = frame_buf[5][SW_RIGHT_BIT];
         r.left_pressed  = prev_left & ~left_bit;
         r.right_pressed = prev_right & ~right_bit;
         prev_left  = left_bit;
         prev_right = right_bit;
         if (kept_sticks[0] <= cfg_model.arm_x_max && kept_sticks[1] >= cfg_model.arm_y_min) begin
            arm_state = 1'b1;
            arm_frames++;
         end
         // a left press disarms even when the gesture is held
         if (r.left_pressed) begin
            arm_state     = 1'b0;
            r.stop_motors = 1'b1;
            motor_stops++;
         end
         if (r.right_pressed) right_presses++;
      end
      r.thrust = kept_sticks[0];
      r.yaw    = kept_sticks[1];
      r.pitch  = kept_sticks[2];
      r.roll   = kept_sticks[3];
      r.armed  = arm_state;
      expected_frame_reports.push_back(r);
   endtask

   // stick value, biased toward the ends of the range
   function automatic logic [BYTE_W-1:0] stick_value();
      if ($urandom_range(0, 4) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly well-formed frames; some noise, bad headers and bad checks
   function automatic frame_vec random_frame();
      frame_vec          f;
      int unsigned       kind;
      logic [BYTE_W-1:0] flip;
      kind = $urandom_range(0, 99);
      flip = 8'($urandom_range(1, 255));
      f[0] = cfg_model.header_value;
      for (int i = 1; i < 5; i++) f[i] = stick_value();
      if ($urandom_range(0, 3) == 0) begin
         f[1] = 8'($urandom_range(0, cfg_model.arm_x_max));
         f[2] = 8'($urandom_range(cfg_model.arm_y_min, 255));
      end
      f[5] = 8'($urandom);
      f[6] = check_byte(f);
      if (kind < 8) begin
         for (int i = 0; i < 7; i++) f[i] = 8'($urandom);
      end else if (kind < 16) begin
         f[0] = f[0] ^ flip;
      end else if (kind < 24) begin
         f[6] = f[6] ^ flip;
      end
      return f;
   endfunction

   // one request; leaves tvalid high so the next byte can follow at once
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_accepted++;
      decode_rx_byte(b);
   endtask

   task automatic send_frame(input frame_vec f);
      for (int i = 0; i < 7; i++) send_byte(f[i]);
   endtask

   // stop sending and wait until every report is in
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_frame_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [BYTE_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_HEADER:    cfg_model.header_value = v;
         CSR_ARM_X_MAX: cfg_model.arm_x_max    = v;
         CSR_ARM_Y_MIN: cfg_model.arm_y_min    = v;
         default: ;
      endcase
   endtask

   task automatic load_settings(input cfg_type s);
      write_register(CSR_HEADER, s.header_value);
      write_register(CSR_ARM_X_MAX, s.arm_x_max);
      write_register(CSR_ARM_Y_MIN, s.arm_y_min);
      csr_we <= 1'b0;
   endtask

   task automatic compare_field(input string field, input logic [BYTE_W-1:0] want,
                                input logic [BYTE_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $realtime, field, want, got);
      end
   endtask

   // result side: ready with random bursts of stall, plus one long hold
   initial begin : result_sink
      @(negedge reset);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare each accepted report with the oldest prediction
   always @(posedge clock) begin : check_reports
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frame_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] report with none expected: %h", $realtime, rsp_tdata);
         end else begin
            want = expected_frame_reports.pop_front();
            reports_checked++;
            compare_field("frame_ok",      8'(want.frame_ok),      8'(rsp_tdata[0]));
            compare_field("error_code",    8'(want.error_code),    8'(rsp_tdata[2:1]));
            compare_field("thrust",        want.thrust,            rsp_tdata[10:3]);
            compare_field("yaw",           want.yaw,               rsp_tdata[18:11]);
            compare_field("pitch",         want.pitch,             rsp_tdata[26:19]);
            compare_field("roll",          want.roll,              rsp_tdata[34:27]);
            compare_field("left_pressed",  8'(want.left_pressed),  8'(rsp_tdata[35]));
            compare_field("right_pressed", 8'(want.right_pressed), 8'(rsp_tdata[36]));
            compare_field("armed",         8'(want.armed),         8'(rsp_tdata[37]));
            compare_field("stop_motors",   8'(want.stop_motors),   8'(rsp_tdata[38]));
            compare_field("pad",           8'h00,                  8'(rsp_tdata[39]));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      cfg_type  settings [4];
      frame_vec f;
      directed_reports[0] = frame_report(1'b1, ERR_NONE, 8'h00, 8'hFF, 8'hA5, 8'h5A,
                                         1'b0, 1'b0, 1'b1, 1'b0);
      directed_reports[1] = frame_report(1'b0, ERR_HEADER, 8'h00, 8'hFF, 8'hA5, 8'h5A,
                                         1'b0, 1'b0, 1'b1, 1'b0);
      directed_reports[2] = frame_report(1'b0, ERR_CHECK, 8'h00, 8'hFF, 8'hA5, 8'h5A,
                                         1'b0, 1'b0, 1'b1, 1'b0);
      directed_reports[3] = frame_report(1'b1, ERR_NONE, 8'h05, 8'hFA, 8'hFF, 8'hFF,
                                         1'b1, 1'b1, 1'b0, 1'b1);
      // header, arm_x_max, arm_y_min
      settings[0] = {8'h00, 8'h00, 8'hFF};   // arming only at the very corner
      settings[1] = {8'hFF, 8'hFF, 8'h00};   // every good frame without a left press arms
      settings[2] = {8'($urandom), 8'($urandom), 8'($urandom)};
      settings[3] = {HEADER_RST, ARM_X_MAX_RST, ARM_Y_MIN_RST};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed frames under reset settings; the typed report replaces the model's
      for (int row = 0; row < DIRECTED_FRAMES; row++) begin
         for (int i = 0; i < 7; i++) f[i] = directed_frames[row][i];
         send_frame(f);
         void'(expected_frame_reports.pop_back());
         expected_frame_reports.push_back(directed_reports[row]);
      end
      wait_drained();

      // random frames, one phase per register setting
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 1) write_register(CSR_UNUSED, 8'($urandom));
         load_settings(settings[phase]);
         if (phase == 3) idle_on = 1'b0;
         for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
            if (phase == 1 && k == 0) hold_results = 1'b1;
            if (phase == 2 && k == FRAMES_PER_PHASE / 2) wait_drained();
            send_frame(random_frame());
         end
         wait_drained();
      end

      $display("Covered %0d bytes in %0d frames: %0d good, %0d bad header, %0d bad check",
               bytes_accepted, bytes_accepted / 7, good_frames, header_errors, check_errors);
      $display("%0d reports checked; %0d arming frames, %0d motor stops, %0d right presses",
               reports_checked, arm_frames, motor_stops, right_presses);
      if (mismatch_count == 0 && expected_frame_reports.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> remote_control_frame_receiver.f
+incdir+src
src/rcfr_pkg.sv
src/rcfr_assembler.sv
src/rcfr_decoder.sv
src/remote_control_frame_receiver.sv
src/rcfr_checker.sv
tb/sv/tb_remote_control_frame_receiver.sv
